// ===== hw/rtl/dst_pkg.sv =====
// dst_pkg: shared types and constants for the descriptor slot table
// holds table geometry, command and status codes, sequencer states and
// the request structs between the sequencer and the slot store
`timescale 1ns / 1ps

package dst_pkg;

  // table geometry
  localparam int SLOTS = 64;
  localparam int IDX_W = 6;
  localparam int KEY_W = 31;
  localparam int CNT_W = 7;
  localparam int CMD_W = 3;
  localparam int QRY_W = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LIST   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 3'd4;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK,
    ST_NOT_FOUND,
    ST_FULL,
    ST_BAD_KEY,
    ST_BAD_INDEX,
    ST_EMPTY
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_RESP
  } state_t;

  // store update kinds
  typedef enum logic [1:0] {
    OP_NONE,
    OP_SET,
    OP_CLEAR
  } tbl_op_t;

  // write request into the slot store
  typedef struct packed {
    tbl_op_t          op;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] key;
  } tbl_wr_t;

  // registered read data from the slot store
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
  } tbl_rd_t;

endpackage

// ===== hw/rtl/dst_table.sv =====
// dst_table: slot store with one write port and one registered read port
// keys live in a memory, occupancy in per-slot flops cleared at reset
// depends on dst_pkg
`timescale 1ns / 1ps

module dst_table import dst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_addr,
  output tbl_rd_t          rd,
  input  tbl_wr_t          wr,
  output logic [CNT_W-1:0] count
);

  logic [KEY_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0] used;
  logic [KEY_W-1:0] rd_key;
  logic             rd_vld;

  // key memory, written only on insert
  always_ff @(posedge clk) begin
    if (wr.op == OP_SET) begin
      mem[wr.addr] <= wr.key;
    end
    rd_key <= mem[rd_addr];
  end

  // occupancy bits and count
  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      count <= '0;
    end else begin
      case (wr.op)
        OP_SET: begin
          used[wr.addr] <= 1'b1;
          count         <= count + CNT_W'(1);
        end
        OP_CLEAR: begin
          used[wr.addr] <= 1'b0;
          count         <= count - CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // occupancy read, aligned with the key read
  always_ff @(posedge clk) begin
    rd_vld <= used[rd_addr];
  end

  assign rd = '{vld: rd_vld, key: rd_key};

endmodule

// ===== hw/rtl/descriptor_slot_table.sv =====
// descriptor_slot_table: keyed slot table with insert, delete, find, list
// and index check, walked one slot per cycle by a small sequencer, unless
// list output stalls; depends on dst_pkg and dst_table
//
// Usage: a request (cmd, key, slot_query) is taken when in_valid is high and
// in_stall is low. in_stall stays high from acceptance until the request's
// last result has been loaded into the output register. Results leave on
// out_valid / out_stall; a result is held unchanged while out_stall is high.
// Insert, delete and find walk the slots through the single read port and
// the shared key comparator, one slot per cycle, stopping at a match.
// List walks all SLOTS slots and emits one result per occupied slot, the
// last one marked, or one empty result when none is occupied; a stalled
// output pauses the walk. Check-index reads only the queried slot, while
// a zero key or an out-of-range index is answered without any walk;
// command codes 5 to 7 give no result.
// The next request is accepted in the cycle after the last result is
// loaded, so the output register may still be waiting on the receiver.
// Reset clears every slot to empty and the occupied count to zero at once;
// no request is lost or repeated whatever the pattern of stalls.
`timescale 1ns / 1ps

module descriptor_slot_table import dst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] cmd,
  input  logic [KEY_W-1:0] key,
  input  logic [QRY_W-1:0] slot_query,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       status,
  output logic [IDX_W-1:0] slot_index,
  output logic [KEY_W-1:0] slot_key,
  output logic [CNT_W-1:0] occupied,
  output logic             last
);

  state_t           state, state_next;
  logic [CMD_W-1:0] cmd_q, cmd_q_next;
  logic [KEY_W-1:0] key_q, key_q_next;
  logic [QRY_W-1:0] query_q, query_q_next;
  logic [IDX_W-1:0] p_idx, p_idx_next;
  logic             empty_found, empty_found_next;
  logic [IDX_W-1:0] empty_idx, empty_idx_next;
  logic             hold_vld, hold_vld_next;
  status_t          res_status, res_status_next;
  logic [IDX_W-1:0] res_idx, res_idx_next;
  logic [KEY_W-1:0] res_key, res_key_next;
  tbl_op_t          res_op, res_op_next;

  status_t          out_status;
  logic             load;
  status_t          load_status;
  logic [IDX_W-1:0] load_idx;
  logic [KEY_W-1:0] load_key;
  logic [CNT_W-1:0] load_occ;
  logic             load_last;

  logic [IDX_W-1:0] rd_addr;
  tbl_rd_t          rd;
  tbl_wr_t          wr;
  logic [CNT_W-1:0] count;

  logic             hit;
  logic             last_slot;
  logic             out_free;
  logic             key_zero;
  logic             q_in_range;

  // slot store
  dst_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd      (rd),
    .wr      (wr),
    .count   (count)
  );

  // shared key comparator and walk status
  assign hit        = rd.vld && (rd.key == key_q);
  assign last_slot  = (p_idx == IDX_W'(SLOTS - 1));
  assign out_free   = !out_valid || !out_stall;
  assign key_zero   = (key_q == '0);
  assign q_in_range = !query_q[QRY_W-1] &&
                      ({1'b0, query_q[QRY_W-2:0]} < QRY_W'(SLOTS));

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request and walk registers
  always_ff @(posedge clk) begin
    cmd_q       <= cmd_q_next;
    key_q       <= key_q_next;
    query_q     <= query_q_next;
    p_idx       <= p_idx_next;
    empty_found <= empty_found_next;
    empty_idx   <= empty_idx_next;
    hold_vld    <= hold_vld_next;
    res_status  <= res_status_next;
    res_idx     <= res_idx_next;
    res_key     <= res_key_next;
    res_op      <= res_op_next;
  end

  // sequencer next state, store access and output loads
  always_comb begin
    state_next       = state;
    cmd_q_next       = cmd_q;
    key_q_next       = key_q;
    query_q_next     = query_q;
    p_idx_next       = p_idx;
    empty_found_next = empty_found;
    empty_idx_next   = empty_idx;
    hold_vld_next    = hold_vld;
    res_status_next  = res_status;
    res_idx_next     = res_idx;
    res_key_next     = res_key;
    res_op_next      = res_op;
    in_stall         = (state != S_IDLE);
    rd_addr          = p_idx + IDX_W'(1);
    wr               = '{op: OP_NONE, addr: res_idx, key: key_q};
    load             = 1'b0;
    load_status      = res_status;
    load_idx         = res_idx;
    load_key         = res_key;
    load_occ         = count;
    load_last        = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_q_next   = cmd;
          key_q_next   = key;
          query_q_next = slot_query;
          state_next   = S_START;
        end
      end

      S_START: begin
        // first read issued here, result registers cleared
        p_idx_next       = (cmd_q == CMD_CHECK) ? query_q[IDX_W-1:0] : '0;
        rd_addr          = p_idx_next;
        empty_found_next = 1'b0;
        hold_vld_next    = 1'b0;
        res_status_next  = ST_OK;
        res_idx_next     = '0;
        res_key_next     = '0;
        res_op_next      = OP_NONE;
        case (cmd_q)
          CMD_INSERT, CMD_DELETE, CMD_FIND: begin
            if (key_zero) begin
              res_status_next = ST_BAD_KEY;
              state_next      = S_RESP;
            end else begin
              state_next = S_SCAN;
            end
          end
          CMD_LIST: state_next = S_SCAN;
          CMD_CHECK: begin
            if (!q_in_range) begin
              res_status_next = ST_BAD_INDEX;
              state_next      = S_RESP;
            end else begin
              state_next = S_SCAN;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end

      S_SCAN: begin
        p_idx_next = p_idx + IDX_W'(1);
        case (cmd_q)
          CMD_INSERT: begin
            if (hit) begin
              res_idx_next = p_idx;
              state_next   = S_RESP;
            end else begin
              // remember the lowest empty slot
              if (!rd.vld && !empty_found) begin
                empty_found_next = 1'b1;
                empty_idx_next   = p_idx;
              end
              if (last_slot) begin
                state_next = S_RESP;
                if (empty_found || !rd.vld) begin
                  res_idx_next = empty_found ? empty_idx : p_idx;
                  res_op_next  = OP_SET;
                end else begin
                  res_status_next = ST_FULL;
                end
              end
            end
          end

          CMD_DELETE, CMD_FIND: begin
            if (hit) begin
              res_idx_next = p_idx;
              res_op_next  = (cmd_q == CMD_DELETE) ? OP_CLEAR : OP_NONE;
              state_next   = S_RESP;
            end else if (last_slot) begin
              res_status_next = ST_NOT_FOUND;
              state_next      = S_RESP;
            end
          end

          CMD_CHECK: begin
            res_status_next = rd.vld ? ST_OK : ST_NOT_FOUND;
            res_idx_next    = rd.vld ? p_idx : '0;
            state_next      = S_RESP;
          end

          CMD_LIST: begin
            if (rd.vld && hold_vld && !out_free) begin
              // output busy: re-read this slot and hold the walk
              rd_addr    = p_idx;
              p_idx_next = p_idx;
            end else begin
              // push the held entry, keep the new one back for last marking
              if (rd.vld) begin
                load          = hold_vld;
                res_idx_next  = p_idx;
                res_key_next  = rd.key;
                hold_vld_next = 1'b1;
              end
              if (last_slot) begin
                state_next = S_RESP;
                if (!rd.vld && !hold_vld) begin
                  res_status_next = ST_EMPTY;
                end
              end
            end
          end

          default: state_next = S_IDLE;
        endcase
      end

      S_RESP: begin
        // final result goes out together with the store update
        if (out_free) begin
          load      = 1'b1;
          load_last = 1'b1;
          wr.op     = res_op;
          case (res_op)
            OP_SET:   load_occ = count + CNT_W'(1);
            OP_CLEAR: load_occ = count - CNT_W'(1);
            default:  load_occ = count;
          endcase
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= load_status;
      slot_index <= load_idx;
      slot_key   <= load_key;
      occupied   <= load_occ;
      last       <= load_last;
    end
  end

  assign status = out_status;

  // occupied count never exceeds the table size
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occupied <= CNT_W'(SLOTS)))
    else $error("occupied count above table size");

  // only list results carry a key, and those are always ok
  a_key_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (slot_key != '0) |-> (out_status == ST_OK))
    else $error("key carried on a failed result");

  // failed results point at slot zero and end the request
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != ST_OK) |-> (slot_index == '0) && last)
    else $error("failed result with slot or without last");

  // the store changes only when the final result is loaded
  a_wr_load: assert property (@(posedge clk) disable iff (rst)
    (wr.op != OP_NONE) |-> load && load_last)
    else $error("store written outside final result");

endmodule

// ===== tb/sv/descriptor_slot_table_tb.sv =====
// descriptor_slot_table_tb: self-checking bench for the descriptor slot table
// random insert, delete, find, list and index-check requests with idle gaps
// and output stalls; depends on dst_pkg and descriptor_slot_table
`timescale 1ns / 1ps

import dst_pkg::*;

// one expected result of the table
typedef struct {
  status_t          status;
  logic [IDX_W-1:0] slot_index;
  logic [KEY_W-1:0] slot_key;
  logic [CNT_W-1:0] occupied;
  logic             last;
} slot_result_t;

// shadow copy of the table and the results it predicts
class slot_table_scoreboard;
  logic [KEY_W-1:0] slot_keys [SLOTS];
  logic [CNT_W-1:0] entry_count;
  slot_result_t     expected_q [$];
  int               mismatches;

  function new();
    foreach (slot_keys[i]) slot_keys[i] = '0;
    entry_count = '0;
    mismatches = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // occupied count is taken after the table update, as the block reports it
  function void expect_result(status_t st, int idx, logic [KEY_W-1:0] k, logic lst);
    slot_result_t r;
    r.status     = st;
    r.slot_index = idx[IDX_W-1:0];
    r.slot_key   = k;
    r.occupied   = entry_count;
    r.last       = lst;
    expected_q.push_back(r);
  endfunction

  // apply one accepted request to the shadow table
  function void note_request(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                             logic signed [QRY_W-1:0] q);
    int i, hit, free_slot, listed, qi;
    hit = -1;
    free_slot = -1;
    listed = 0;
    qi = q;
    for (i = 0; i < SLOTS; i++) begin
      if (hit < 0 && slot_keys[i] == k) hit = i;
      if (free_slot < 0 && slot_keys[i] == '0) free_slot = i;
    end
    // zero key is rejected before the lookup result is used
    if ((c == CMD_INSERT || c == CMD_DELETE || c == CMD_FIND) && k == '0) begin
      expect_result(ST_BAD_KEY, 0, '0, 1'b1);
      return;
    end
    case (c)
      CMD_INSERT: begin
        if (hit >= 0) expect_result(ST_OK, hit, '0, 1'b1);
        else if (free_slot < 0) expect_result(ST_FULL, 0, '0, 1'b1);
        else begin
          slot_keys[free_slot] = k;
          entry_count++;
          expect_result(ST_OK, free_slot, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (hit < 0) expect_result(ST_NOT_FOUND, 0, '0, 1'b1);
        else begin
          slot_keys[hit] = '0;
          entry_count--;
          expect_result(ST_OK, hit, '0, 1'b1);
        end
      end
      CMD_FIND: begin
        if (hit < 0) expect_result(ST_NOT_FOUND, 0, '0, 1'b1);
        else expect_result(ST_OK, hit, '0, 1'b1);
      end
      CMD_LIST: begin
        for (i = 0; i < SLOTS; i++) begin
          if (slot_keys[i] != '0) begin
            expect_result(ST_OK, i, slot_keys[i], 1'b0);
            listed++;
          end
        end
        if (listed == 0) expect_result(ST_EMPTY, 0, '0, 1'b1);
        else expected_q[expected_q.size() - 1].last = 1'b1;
      end
      CMD_CHECK: begin
        if (qi < 0 || qi >= SLOTS) expect_result(ST_BAD_INDEX, 0, '0, 1'b1);
        else if (slot_keys[qi] == '0) expect_result(ST_NOT_FOUND, 0, '0, 1'b1);
        else expect_result(ST_OK, qi, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // compare one accepted result with the oldest expectation
  function void check_result(logic [2:0] st, logic [IDX_W-1:0] idx, logic [KEY_W-1:0] k,
                             logic [CNT_W-1:0] occ, logic lst);
    slot_result_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("slot table: unexpected result status=%0d slot=%0d key=%h occ=%0d last=%b",
                 st, idx, k, occ, lst);
      return;
    end
    want = expected_q.pop_front();
    if (st !== want.status || idx !== want.slot_index || k !== want.slot_key ||
        occ !== want.occupied || lst !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("slot table: mismatch expected status=%0d slot=%0d key=%h occ=%0d last=%b",
                 want.status, want.slot_index, want.slot_key, want.occupied, want.last);
        $display("slot table: mismatch got      status=%0d slot=%0d key=%h occ=%0d last=%b",
                 st, idx, k, occ, lst);
      end
    end
  endfunction
endclass

module descriptor_slot_table_tb;

  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
  localparam logic [KEY_W-1:0] KEY_MAX     = '1;
  localparam int RANDOM_ITEMS  = 175;
  localparam int GROW_END      = 100;
  localparam int MIX_END       = 150;
  localparam int PRESSURE_HOLD = 400;
  localparam int DRAIN_CYCLES  = 100;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;
  logic [QRY_W-1:0] slot_query;
  logic             out_valid;
  logic             out_stall;
  logic [2:0]       status;
  logic [IDX_W-1:0] slot_index;
  logic [KEY_W-1:0] slot_key;
  logic [CNT_W-1:0] occupied;
  logic             last;

  // quiet stretches with no idling, and the one long receiver hold-off
  logic quiet;
  logic pressure_req;

  slot_table_scoreboard sb = new;

  descriptor_slot_table dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

  // idle length: mostly none or short, a few long
  function automatic int pick_idle();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 20);
  endfunction

  // zero, a fresh key, or one already in the table
  function automatic logic [KEY_W-1:0] pick_key(int fresh_pct);
    int roll, s, i;
    logic [KEY_W-1:0] k;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 5 + fresh_pct || sb.entry_count == 0) begin
      s = $urandom_range(0, 15);
      if (s == 0) return KEY_MAX;
      if (s == 1) return KEY_W'(1);
      k = KEY_W'($urandom());
      return (k == '0) ? KEY_MAX : k;
    end
    s = $urandom_range(0, SLOTS - 1);
    for (i = 0; i < SLOTS; i++)
      if (sb.slot_keys[(s + i) % SLOTS] != '0) return sb.slot_keys[(s + i) % SLOTS];
    return KEY_MAX;
  endfunction

  // offer one request, hold it until taken, then idle for a random gap, possibly none
  task automatic send_request(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                              logic [QRY_W-1:0] q);
    int gap;
    in_valid   <= 1'b1;
    cmd        <= c;
    key        <= k;
    slot_query <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(c, k, q);
    gap = pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: check on every accepted result, stall at random
  initial begin : result_sink
    int hold_left;
    bit pressure_done;
    hold_left = 0;
    pressure_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(status, slot_index, slot_key, occupied, last);
      if (hold_left == 0 && pressure_req && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = PRESSURE_HOLD;
      end else if (hold_left == 0) begin
        hold_left = pick_idle();
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int n, roll;
    logic [CMD_W-1:0] c;
    logic [KEY_W-1:0] k;
    logic [QRY_W-1:0] q;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    cmd          <= CMD_INSERT;
    key          <= '0;
    slot_query   <= '0;
    quiet        <= 1'b0;
    pressure_req <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, zero key, extreme keys, duplicates, index edges, reserved codes
    send_request(CMD_LIST, '0, '0);
    send_request(CMD_FIND, KEY_W'(5), '0);
    send_request(CMD_DELETE, KEY_W'(5), '0);
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_DELETE, '0, '0);
    send_request(CMD_FIND, '0, '0);
    send_request(CMD_INSERT, KEY_MAX, '0);
    send_request(CMD_INSERT, KEY_W'(1), '0);
    send_request(CMD_INSERT, KEY_MAX, '0);
    send_request(CMD_FIND, KEY_W'(1), '0);
    send_request(CMD_CHECK, '0, QRY_W'(0));
    send_request(CMD_CHECK, '0, QRY_W'(1));
    send_request(CMD_CHECK, '0, QRY_W'(2));
    send_request(CMD_CHECK, '0, QRY_W'(SLOTS - 1));
    send_request(CMD_CHECK, '0, QRY_W'(SLOTS));
    send_request(CMD_CHECK, '0, 8'hFF);
    send_request(CMD_CHECK, '0, 8'h80);
    send_request(CMD_CHECK, '0, 8'h7F);
    send_request(CMD_LIST, '0, '0);
    send_request(CMD_DELETE, KEY_MAX, '0);
    send_request(CMD_INSERT, KEY_W'(7), '0);
    for (n = CMD_RSVD_LO; n <= CMD_RSVD_HI; n++)
      send_request(n[CMD_W-1:0], KEY_W'($urandom()), QRY_W'($urandom()));
    send_request(CMD_LIST, '0, '0);

    // random: fill toward full, then mixed traffic, then drain
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) quiet <= ($urandom_range(0, 3) == 0);
      if (n == 40) pressure_req <= 1'b1;
      roll = $urandom_range(0, 99);
      c = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
      if (n < GROW_END) begin
        if (roll < 84) c = CMD_INSERT;
        else if (roll < 89) c = CMD_FIND;
        else if (roll < 93) c = CMD_CHECK;
        else if (roll < 96) c = CMD_DELETE;
        else if (roll < 98) c = CMD_LIST;
      end else if (n < MIX_END) begin
        if (roll < 30) c = CMD_INSERT;
        else if (roll < 50) c = CMD_DELETE;
        else if (roll < 70) c = CMD_FIND;
        else if (roll < 85) c = CMD_CHECK;
        else if (roll < 95) c = CMD_LIST;
      end else begin
        if (roll < 50) c = CMD_DELETE;
        else if (roll < 60) c = CMD_INSERT;
        else if (roll < 75) c = CMD_FIND;
        else if (roll < 90) c = CMD_CHECK;
        else if (roll < 97) c = CMD_LIST;
      end
      if (c == CMD_INSERT) k = pick_key(n < GROW_END ? 90 : 55);
      else k = pick_key(20);
      if (c == CMD_CHECK && $urandom_range(0, 3) != 0) q = QRY_W'($urandom_range(0, SLOTS - 1));
      else q = QRY_W'($urandom());
      send_request(c, k, q);
    end

    // wait out every outstanding result, then a quiet tail
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
